FILE: sv/contiguous_fit_allocator_macros.svh
// Assertion macros for the contiguous fit allocator.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CFA_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CFA_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

FILE: sv/cfa_pkg.sv
// Package with types, codes and sizes for the contiguous fit allocator.
package cfa_pkg;
    localparam int unsigned TotalFrames = 256;
    localparam int unsigned IdWidth     = 8;
    localparam int unsigned FrameBits   = $clog2(TotalFrames);
    localparam int unsigned CountBits   = FrameBits + 1;

    typedef enum logic [1:0] {
        ST_PLACED    = 2'd0,
        ST_COMPACTED = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_RELEASED  = 2'd3
    } t_status;

    localparam logic [1:0] POL_NEXT  = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] owner_id;
        logic [8:0] frame_count;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] start_frame;
        logic [7:0] moved_frames;
        logic [8:0] freed_frames;
    } t_out_beat;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_COUNT, S_SRCH, S_SRCH2, S_COMPACT, S_FILLZ, S_SRCH3,
        S_PLACE, S_RELEASE, S_DONE
    } t_state;

    // Datapath scan commands.
    typedef enum logic [3:0] {
        C_NONE, C_START, C_CLEAR, C_COUNT, C_SRCH, C_SRCH_WRAP, C_COMPACT,
        C_FILLZ, C_PLACE, C_RELEASE
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        logic    first;   // first cycle of a sweep: reset index and trackers
        logic    from_zero; // search starts at frame 0
    } t_cmd;

    typedef struct packed {
        logic last;       // final cycle of the current sweep
        logic found;      // search produced a run
        logic short_space;// count rejects the request
    } t_sts;
endpackage

FILE: sv/cfa_datapath.sv
// Datapath: frame store, sweep index and run trackers.
module cfa_datapath
    import cfa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_req,
    input  logic [1:0] i_policy,
    output t_sts      o_sts,
    output t_out_beat o_res
);
    localparam int unsigned Last = TotalFrames - 1;

    logic [IdWidth-1:0]   r_mem [TotalFrames];
    logic [IdWidth-1:0]   r_rd;              // registered read of the frame at r_idx
    logic [CountBits-1:0] r_idx, n_idx;      // sweep index, reaches TotalFrames
    logic [FrameBits-1:0] r_dst, n_dst;      // compaction write pointer
    logic [CountBits-1:0] r_len, n_len;
    logic [FrameBits-1:0] r_rstart, n_rstart;
    logic [FrameBits-1:0] r_best, n_best;
    logic [CountBits-1:0] r_blen, n_blen;
    logic                 r_found, n_found;
    logic [CountBits-1:0] r_tally, n_tally;  // free count, freed or moved
    logic [FrameBits-1:0] r_nfs, n_nfs;
    logic [FrameBits-1:0] r_lim, n_lim;      // bound of the wrap search

    logic [IdWidth-1:0] id;
    logic [FrameBits-1:0] fi;
    logic [IdWidth-1:0]  rd;
    logic                we;
    logic [FrameBits-1:0] wa;
    logic [IdWidth-1:0]  wd;
    logic                is_free, at_end;
    logic [CountBits-1:0] len_inc;
    logic                 fits, better, sized;

    assign id = i_req.owner_id[IdWidth-1:0];
    assign fi = r_idx[FrameBits-1:0];
    assign rd = r_rd;
    assign is_free = (rd == '0);
    assign sized = (i_policy == POL_BEST) || (i_policy == POL_WORST);
    assign len_inc = r_len + 1'b1;

    // The read address is the next sweep index, so r_rd holds the frame at r_idx.
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[n_idx[FrameBits-1:0]];
    end

    always_comb begin
        n_idx = r_idx + 1'b1; n_dst = r_dst; n_len = r_len; n_rstart = r_rstart;
        n_best = r_best; n_blen = r_blen; n_found = r_found; n_tally = r_tally;
        n_nfs = r_nfs; n_lim = r_lim;
        we = 1'b0; wa = fi; wd = '0;
        at_end = (r_idx == CountBits'(Last));
        fits = 1'b0; better = 1'b0;
        o_sts = '0;
        if (i_cmd.first) begin
            n_idx = '0; n_dst = '0; n_len = '0; n_blen = '0;
            if (i_cmd.op != C_PLACE) n_found = 1'b0;
            if (i_cmd.op == C_SRCH && !i_cmd.from_zero && !sized) n_idx = {1'b0, r_nfs};
            if (i_cmd.op == C_SRCH_WRAP) n_lim = r_nfs;
            if (i_cmd.op == C_COUNT || i_cmd.op == C_RELEASE || i_cmd.op == C_COMPACT)
                n_tally = '0;
            if (i_cmd.op == C_PLACE) n_idx = {1'b0, r_best};
        end else begin
            unique case (i_cmd.op)
                C_START: begin
                    n_nfs = '0;
                end
                C_CLEAR: begin
                    we = 1'b1;
                    o_sts.last = at_end;
                end
                C_COUNT: begin
                    if (is_free) n_tally = r_tally + 1'b1;
                    o_sts.last = at_end;
                end
                C_RELEASE: begin
                    if (rd == id && id != '0) begin
                        we = 1'b1; n_tally = r_tally + 1'b1;
                    end
                    o_sts.last = at_end;
                end
                C_COMPACT: begin
                    if (!is_free) begin
                        if (r_dst != fi) begin
                            we = 1'b1; wa = r_dst; wd = rd; n_tally = r_tally + 1'b1;
                        end
                        n_dst = r_dst + 1'b1;
                    end
                    o_sts.last = at_end;
                end
                C_FILLZ: begin
                    // Clear frames from the compaction write pointer upward.
                    if (fi >= r_dst) we = 1'b1;
                    o_sts.last = (fi == FrameBits'(Last));
                end
                C_SRCH, C_SRCH_WRAP: begin
                    if (sized) begin
                        if (is_free && r_idx < CountBits'(TotalFrames)) begin
                            if (r_len == '0) n_rstart = fi;
                            n_len = len_inc;
                        end else begin
                            fits = (r_len >= i_req.frame_count) && (r_len != '0);
                            better = !r_found || ((i_policy == POL_WORST) ?
                                (r_len > r_blen) : (r_len < r_blen));
                            if (fits && better) begin
                                n_found = 1'b1; n_best = r_rstart; n_blen = r_len;
                            end
                            n_len = '0;
                        end
                        o_sts.last = (r_idx == CountBits'(TotalFrames));
                    end else begin
                        if (!is_free) n_len = '0;
                        else begin
                            if (r_len == '0) n_rstart = fi;
                            n_len = len_inc;
                            if (len_inc >= i_req.frame_count) begin
                                n_found = 1'b1;
                                n_best = (r_len == '0) ? fi : r_rstart;
                            end
                        end
                        o_sts.last = at_end || (i_cmd.op == C_SRCH_WRAP &&
                            r_idx + 1'b1 >= {1'b0, r_lim}) || n_found;
                    end
                end
                C_PLACE: begin
                    we = 1'b1; wd = id;
                    o_sts.last = (r_idx - {1'b0, r_best} + 1'b1 >= i_req.frame_count)
                        || at_end;
                    if (o_sts.last) n_nfs = FrameBits'({1'b0, r_best} + i_req.frame_count);
                end
                default: ;
            endcase
        end
        o_sts.found = n_found;
        o_sts.short_space = (i_req.frame_count > r_tally) || (i_req.frame_count == '0)
            || (id == '0);
        o_res.status = '0;
        o_res.start_frame = 8'(r_best);
        o_res.moved_frames = 8'(r_tally);
        o_res.freed_frames = 9'(r_tally);
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_dst <= n_dst; r_len <= n_len; r_rstart <= n_rstart;
        r_best <= n_best; r_blen <= n_blen; r_tally <= n_tally; r_lim <= n_lim;
        if (!i_rst_n) begin
            r_found <= 1'b0; r_nfs <= '0;
        end else begin
            r_found <= n_found; r_nfs <= n_nfs;
        end
    end
endmodule

FILE: sv/cfa_ctrl.sv
// Controller state machine sequencing the datapath sweeps.
module cfa_ctrl
    import cfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_beat i_req,
    output t_in_beat o_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_sts     i_sts,
    input  t_out_beat i_res,
    output t_out_beat o_res,
    output t_cmd     o_cmd
);
    t_state    r_state, n_state;
    logic      r_first, n_first;
    logic      r_comp, n_comp;
    logic      r_ovalid, n_ovalid;
    t_in_beat  r_req, n_req;
    t_out_beat r_res, n_res;
    logic [7:0] r_moved, n_moved;

    assign o_req = r_req;
    assign o_res = r_res;
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_res <= n_res; r_moved <= n_moved;
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_first <= 1'b1; r_comp <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_first <= n_first; r_comp <= n_comp;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state; n_first = 1'b0; n_comp = r_comp; n_req = r_req;
        n_res = r_res; n_moved = r_moved;
        n_ovalid = r_ovalid && !i_out_ready;
        o_in_ready = 1'b0;
        o_cmd = '{op: C_NONE, first: r_first, from_zero: r_comp};
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = C_CLEAR;
                if (!r_first && i_sts.last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = !r_ovalid || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    n_req = i_req; n_first = 1'b1; n_comp = 1'b0; n_moved = '0;
                    n_state = (i_req.operation == OP_RELEASE) ? S_RELEASE : S_COUNT;
                end
            end
            S_RELEASE: begin
                o_cmd.op = C_RELEASE;
                if (!r_first && i_sts.last) n_state = S_DONE;
            end
            S_COUNT: begin
                o_cmd.op = C_COUNT;
                if (!r_first && i_sts.last) begin
                    n_state = S_SRCH; n_first = 1'b1;
                end
            end
            S_SRCH: begin
                o_cmd.op = C_SRCH;
                if (r_first && !r_comp && i_sts.short_space) n_state = S_DONE;
                else if (!r_first && i_sts.last) begin
                    n_first = 1'b1;
                    if (i_sts.found) n_state = S_PLACE;
                    else n_state = S_SRCH2;
                end
            end
            S_SRCH2: begin
                o_cmd.op = C_SRCH_WRAP;
                n_first = 1'b0;
                if (r_first) begin
                    // The wrap half runs under every policy; for next fit it stops at the next-fit start.
                    n_first = 1'b0;
                end else if (i_sts.last) begin
                    n_first = 1'b1;
                    n_state = i_sts.found ? S_PLACE : (r_comp ? S_DONE : S_COMPACT);
                end
            end
            S_COMPACT: begin
                o_cmd.op = C_COMPACT;
                if (!r_first && i_sts.last) begin
                    n_state = S_FILLZ;
                end
            end
            S_FILLZ: begin
                o_cmd.op = C_FILLZ;
                if (i_sts.last) begin
                    n_state = S_SRCH3; n_first = 1'b1; n_comp = 1'b1;
                    n_moved = i_res.moved_frames;
                end
            end
            S_SRCH3: begin
                o_cmd.op = C_SRCH; o_cmd.from_zero = 1'b1;
                if (!r_first && i_sts.last) begin
                    n_first = 1'b1;
                    n_state = i_sts.found ? S_PLACE : S_DONE;
                end
            end
            S_PLACE: begin
                o_cmd.op = C_PLACE;
                if (!r_first && i_sts.last) n_state = S_DONE;
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_res = '0;
                if (r_req.operation == OP_RELEASE) begin
                    n_res.status = ST_RELEASED;
                    n_res.freed_frames = i_res.freed_frames;
                end else if (i_sts.found) begin
                    n_res.status = r_comp ? ST_COMPACTED : ST_PLACED;
                    n_res.start_frame = i_res.start_frame;
                    n_res.moved_frames = r_comp ? r_moved : '0;
                end else begin
                    n_res.status = ST_REJECTED;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: sv/contiguous_fit_allocator.sv
// Top level of the contiguous fit allocator: controller, datapath, policy register.
// A release or an early rejection takes one sweep of the store; an allocate takes
// free count, search and placement sweeps, plus compaction sweeps when no run fits.
// Throughput: one request at a time, set by the store sweeps.
// Reset: synchronous, active low; afterwards a clearing pass empties the store,
// during which no request beat is accepted.
module contiguous_fit_allocator
    import cfa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_data
);
    // The policy register; value three behaves as next fit in the datapath.
    logic [1:0] r_policy;
    t_cmd       cmd;
    t_sts       sts;
    t_in_beat   req;
    t_out_beat  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_policy <= POL_NEXT;
        else if (i_cfg_we) r_policy <= i_cfg_data;
    end

    cfa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_req(i_in_data), .o_req(req),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_sts(sts),
        .i_res(res), .o_res(o_out_data), .o_cmd(cmd)
    );

    cfa_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(req),
        .i_policy(r_policy), .o_sts(sts), .o_res(res)
    );
endmodule

FILE: sv/cfa_checker.sv
// Port-level checker for the contiguous fit allocator, bound to the top level.
`include "contiguous_fit_allocator_macros.svh"
module cfa_checker
    import cfa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);
    `CFA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "result beat dropped while stalled")
    `CFA_ASSERT_IMP(a_rej_zero, i_clk, i_rst_n, o_out_valid &&
        o_out_data.status == ST_REJECTED, o_out_data.start_frame == '0,
        "rejected beat carries a start frame")
    `CFA_ASSERT_IMP(a_place_nofree, i_clk, i_rst_n, o_out_valid &&
        o_out_data.status != ST_RELEASED, o_out_data.freed_frames == '0,
        "allocation result reports freed frames")
    `CFA_ASSERT_NXT(a_one_at_time, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "second request taken while one is in progress")
endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);
